@@ src/pirl_pkg.sv @@
// pirl_pkg: operation and status codes and the cell control struct
// for the positional insert/remove list; no dependencies
package pirl_pkg;

  localparam int FuncW   = 3;
  localparam int StatusW = 2;
  localparam int PosW    = 5;
  localparam int CountW  = 5;
  localparam int DataW   = 32;

  typedef enum logic [FuncW-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_INSERT_AT  = 3'd2,
    FN_POP_FRONT  = 3'd3,
    FN_POP_BACK   = 3'd4,
    FN_REMOVE_AT  = 3'd5
  } func_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // broadcast to every cell in the row
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic signed [DataW-1:0] value;
  } cell_ctl_t;

endpackage

@@ src/positional_insert_remove_list.sv @@
// positional_insert_remove_list: ordered list of signed 32-bit values built
// as a row of pirl_cell slots; depends on pirl_pkg and pirl_cell
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------
//   input   | start, busy            | in_func, in_item_value, in_position
//   result  | out_valid (strobe)     | out_removed_value, out_status,
//           |                        | out_count_after
//
// one beat per cycle: a command taken at an edge updates every cell in
// parallel at that same edge, and its result sits on the out_ ports for the
// following cycle only, and throughput is one per cycle
// busy stays low; the receiver cannot stall, so nothing waits on it
// reset (rst_n low, synchronous) empties the list; cell contents are not
// cleared, since only slots below the count are ever read
module positional_insert_remove_list #(
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [pirl_pkg::FuncW-1:0]       in_func,
  input  logic signed [pirl_pkg::DataW-1:0] in_item_value,
  input  logic [pirl_pkg::PosW-1:0]        in_position,
  output logic                             out_valid,
  output logic signed [pirl_pkg::DataW-1:0] out_removed_value,
  output logic [pirl_pkg::StatusW-1:0]     out_status,
  output logic [pirl_pkg::CountW-1:0]      out_count_after
);
  import pirl_pkg::*;

  // count holds 0..DEPTH; compares run at the wider of count and position
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = (CW > PosW) ? CW : PosW;
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [WW-1:0] DepthW = WW'(DEPTH);
  localparam logic [WW-1:0] OneW   = WW'(1);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          out_valid_r;
  logic signed [DataW-1:0] removed_r;
  status_t       status_r;
  logic [CountW-1:0] count_after_r;

  logic          accept;
  logic [WW-1:0] cnt_w;
  logic [WW-1:0] pos_w;
  logic [WW-1:0] p;
  logic          do_ins;
  logic          do_rem;
  status_t       status;
  logic signed [DataW-1:0] removed;
  logic [WW-1:0] count_after_w;
  cell_ctl_t     ctl;

  logic signed [DataW-1:0] slot_q [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign cnt_w  = WW'(count_r);
  assign pos_w  = WW'(in_position);

  // decode the command against the current count
  always_comb begin
    p      = '0;
    do_ins = 1'b0;
    do_rem = 1'b0;
    status = ST_OK;
    case (in_func)
      FN_PUSH_FRONT, FN_PUSH_BACK, FN_INSERT_AT: begin
        if (in_func == FN_PUSH_BACK) p = cnt_w;
        else if (in_func == FN_INSERT_AT) p = pos_w;
        // position check wins over the full check
        if (p > cnt_w) status = ST_BADPOS;
        else if (cnt_w >= DepthW) status = ST_FULL;
        else do_ins = 1'b1;
      end
      FN_POP_FRONT, FN_POP_BACK, FN_REMOVE_AT: begin
        if (cnt_w == '0) begin
          status = ST_EMPTY;
        end else begin
          if (in_func == FN_POP_BACK) p = cnt_w - OneW;
          else if (in_func == FN_REMOVE_AT) p = pos_w;
          if (p >= cnt_w) status = ST_BADPOS;
          else do_rem = 1'b1;
        end
      end
      default: begin
        // unused codes leave everything alone
        status = ST_OK;
      end
    endcase
  end

  // p is below the count here, so its low bits address a real slot
  assign removed = do_rem ? slot_q[p[IW-1:0]] : '0;

  always_comb begin
    count_nxt = count_r;
    if (accept && do_ins) count_nxt = count_r + CW'(1);
    else if (accept && do_rem) count_nxt = count_r - CW'(1);
  end

  assign count_after_w = WW'(count_nxt);

  // one control word fans out to the whole row
  assign ctl.ins   = accept && do_ins;
  assign ctl.rem   = accept && do_rem;
  assign ctl.value = in_item_value;

  // slot i takes from i-1 on insert and from i+1 on remove
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DataW-1:0] lower;
    logic signed [DataW-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = in_item_value;
    end else begin : g_lo
      assign lower = slot_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper = slot_q[i];
    end else begin : g_hi
      assign upper = slot_q[i+1];
    end
    pirl_cell #(
      .IDX (i),
      .PW  (WW)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .pos     (p),
      .lower_q (lower),
      .upper_q (upper),
      .q       (slot_q[i])
    );
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      removed_r     <= removed;
      status_r      <= status;
      count_after_r <= count_after_w[CountW-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_removed_value = removed_r;
  assign out_status        = status_r;
  assign out_count_after   = count_after_r;

endmodule

@@ src/pirl_cell.sv @@
// pirl_cell: one storage slot of the list row
// depends on pirl_pkg (cell_ctl_t, DataW)
module pirl_cell #(
  parameter int IDX = 0,
  parameter int PW  = 5
) (
  input  logic                             clk,
  input  pirl_pkg::cell_ctl_t              ctl,
  input  logic [PW-1:0]                    pos,
  input  logic signed [pirl_pkg::DataW-1:0] lower_q,
  input  logic signed [pirl_pkg::DataW-1:0] upper_q,
  output logic signed [pirl_pkg::DataW-1:0] q
);
  import pirl_pkg::*;

  localparam logic [PW-1:0] IdxV = PW'(IDX);

  logic signed [DataW-1:0] q_r;
  logic signed [DataW-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (ctl.ins) begin
      if (IdxV == pos) q_nxt = ctl.value;
      else if (IdxV > pos) q_nxt = lower_q;
    end else if (ctl.rem) begin
      if (IdxV >= pos) q_nxt = upper_q;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

@@ src/pirl_chk.sv @@
// pirl_chk: port-level checks on the positional insert/remove list
// depends on pirl_pkg; bound to positional_insert_remove_list below
module pirl_chk #(
  parameter int DEPTH = 16
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic signed [pirl_pkg::DataW-1:0] out_removed_value,
  input logic [pirl_pkg::StatusW-1:0]     out_status,
  input logic [pirl_pkg::CountW-1:0]      out_count_after,
  input logic                             out_valid
);
  import pirl_pkg::*;

  localparam logic [CountW-1:0] DepthC = CountW'(DEPTH);
  localparam logic [CountW-1:0] OneC   = CountW'(1);

  // a result beat in the cycle after each accepted command, and none otherwise
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_valid == $past(start && !busy)))
    else $error("result strobe does not follow accepted command");

  // failed commands return no value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_removed_value == '0))
    else $error("nonzero removed value on failed command");

  // empty and full reports agree with the count
  a_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (((out_status != ST_EMPTY) || (out_count_after == '0)) &&
                   ((out_status != ST_FULL) || (out_count_after == DepthC))))
    else $error("status disagrees with count");

  // back-to-back results move the count by at most one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid) && $past(rst_n)) |->
      ((out_count_after == $past(out_count_after)) ||
       (out_count_after == $past(out_count_after) + OneC) ||
       (out_count_after == $past(out_count_after) - OneC)))
    else $error("count jumped between consecutive results");

endmodule

bind positional_insert_remove_list pirl_chk #(.DEPTH(DEPTH)) u_pirl_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_removed_value (out_removed_value),
  .out_status        (out_status),
  .out_count_after   (out_count_after),
  .out_valid         (out_valid)
);

@@ tb/tb_positional_insert_remove_list.sv @@
`timescale 1ns / 100ps
// tb_positional_insert_remove_list: self-checking bench for the positional insert/remove list,
// a directed table followed by random commands scored against a queue-based list model;
// depends on pirl_pkg and positional_insert_remove_list
module tb_positional_insert_remove_list;
  import pirl_pkg::*;

  localparam int ListDepth  = 16;
  localparam int RandItems  = 1400;
  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 4;

  // func codes the block treats as no-ops
  localparam logic [FuncW-1:0] FN_UNUSED_LO = 3'd6;
  localparam logic [FuncW-1:0] FN_UNUSED_HI = 3'd7;

  localparam logic signed [DataW-1:0] ValMax = 32'h7fff_ffff;
  localparam logic signed [DataW-1:0] ValMin = 32'h8000_0000;

  // one result beat as the block reports it
  typedef struct {
    logic signed [DataW-1:0] removed;
    status_t                 status;
    logic [CountW-1:0]       count;
  } list_result_t;

  // directed command; typed rows carry their answer, the rest use the model
  typedef struct {
    logic [FuncW-1:0]        op;
    logic signed [DataW-1:0] value;
    logic [PosW-1:0]         pos;
    int                      reps;
    bit                      rnd_value;
    bit                      typed;
    list_result_t            want;
  } cmd_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [FuncW-1:0] in_func = '0;
  logic signed [DataW-1:0] in_item_value = '0;
  logic [PosW-1:0] in_position = '0;
  logic out_valid;
  logic signed [DataW-1:0] out_removed_value;
  logic [StatusW-1:0] out_status;
  logic [CountW-1:0] out_count_after;

  // model of the list contents, index 0 is the front
  logic signed [DataW-1:0] model_list[$];
  // results owed by the block, oldest first
  list_result_t due_results[$];
  list_result_t oldest_due;

  int n_taken = 0;
  int n_mismatch = 0;
  int unsigned n_cycles = 0;
  // sender idle pattern: stretches with and without gaps
  int stretch_left = 0;
  bit idle_off = 1'b0;

  positional_insert_remove_list #(
    .DEPTH(ListDepth)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_item_value    (in_item_value),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_removed_value(out_removed_value),
    .out_status       (out_status),
    .out_count_after  (out_count_after)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) n_cycles <= n_cycles + 1;

  // apply one command to the model list and return the beat it should give
  function automatic list_result_t list_apply_op(logic [FuncW-1:0] op,
                                                 logic signed [DataW-1:0] v,
                                                 logic [PosW-1:0] p);
    list_result_t r;
    int n;
    int at;
    n = model_list.size();
    r.removed = '0;
    r.status = ST_OK;
    case (op)
      FN_PUSH_FRONT, FN_PUSH_BACK, FN_INSERT_AT: begin
        at = (op == FN_PUSH_FRONT) ? 0 : (op == FN_PUSH_BACK) ? n : int'(p);
        // position check comes ahead of the full check
        if (at > n) r.status = ST_BADPOS;
        else if (n >= ListDepth) r.status = ST_FULL;
        else model_list.insert(at, v);
      end
      FN_POP_FRONT, FN_POP_BACK, FN_REMOVE_AT: begin
        // empty wins over any position
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          at = (op == FN_POP_FRONT) ? 0 : (op == FN_POP_BACK) ? n - 1 : int'(p);
          if (at >= n) begin
            r.status = ST_BADPOS;
          end else begin
            r.removed = model_list[at];
            model_list.delete(at);
          end
        end
      end
      default: ;
    endcase
    r.count = CountW'(model_list.size());
    return r;
  endfunction

  // result side: one beat per strobe, scored against the oldest owed result
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (due_results.size() == 0) begin
          $display("%0t unexpected beat: expected none, got removed %0d status %0d count %0d",
                   $time, out_removed_value, out_status, out_count_after);
          n_mismatch++;
        end else begin
          oldest_due = due_results.pop_front();
          if (out_removed_value !== oldest_due.removed) begin
            $display("%0t removed_value mismatch: expected %0d, got %0d",
                     $time, oldest_due.removed, out_removed_value);
            n_mismatch++;
          end
          if (out_status !== oldest_due.status) begin
            $display("%0t status mismatch: expected %0d, got %0d",
                     $time, oldest_due.status, out_status);
            n_mismatch++;
          end
          if (out_count_after !== oldest_due.count) begin
            $display("%0t count_after mismatch: expected %0d, got %0d",
                     $time, oldest_due.count, out_count_after);
            n_mismatch++;
          end
        end
      end
      // command beat taken at this edge
      if (start && !busy) n_taken++;
    end
  end

  // drive one command beat, called at a falling edge; returns at the falling
  // edge after the beat was taken, with its result queued
  task automatic send_cmd(input logic [FuncW-1:0] op, input logic signed [DataW-1:0] v,
                          input logic [PosW-1:0] p, input bit typed,
                          input list_result_t want);
    int gap;
    int seen;
    list_result_t got;
    if (stretch_left == 0) begin
      stretch_left = $urandom_range(10, 60);
      idle_off = ($urandom_range(0, 2) == 0);
    end
    stretch_left--;
    gap = idle_off ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start <= 1'b0;
      // junk on the payload while idle, must be ignored
      repeat (gap) begin
        in_func <= FuncW'($urandom);
        in_item_value <= $urandom;
        in_position <= PosW'($urandom);
        @(negedge clk);
      end
    end
    start <= 1'b1;
    in_func <= op;
    in_item_value <= v;
    in_position <= p;
    seen = n_taken;
    do @(negedge clk); while (n_taken == seen);
    got = list_apply_op(op, v, p);
    due_results.push_back(typed ? want : got);
  endtask

  initial begin
    cmd_row_t plan[$];
    cmd_row_t row;
    list_result_t none;
    logic [FuncW-1:0] op;
    logic signed [DataW-1:0] v;
    logic [PosW-1:0] p;
    bit grow;
    bit adds;
    int roll;
    int n;

    none = '{removed: '0, status: ST_OK, count: '0};

    // directed plan: empty list errors, extremes, bad positions, full list
    plan.push_back('{FN_POP_FRONT, 0, 0, 1, 1'b0, 1'b1, '{0, ST_EMPTY, 0}});
    plan.push_back('{FN_POP_BACK, 0, 0, 1, 1'b0, 1'b1, '{0, ST_EMPTY, 0}});
    // remove at on empty: empty regardless of position
    plan.push_back('{FN_REMOVE_AT, 0, 31, 1, 1'b0, 1'b1, '{0, ST_EMPTY, 0}});
    plan.push_back('{FN_UNUSED_LO, 0, 0, 1, 1'b0, 1'b1, '{0, ST_OK, 0}});
    plan.push_back('{FN_PUSH_FRONT, ValMax, 0, 1, 1'b0, 1'b1, '{0, ST_OK, 1}});
    plan.push_back('{FN_PUSH_BACK, ValMin, 31, 1, 1'b0, 1'b1, '{0, ST_OK, 2}});
    plan.push_back('{FN_INSERT_AT, 5, 3, 1, 1'b0, 1'b1, '{0, ST_BADPOS, 2}});
    plan.push_back('{FN_INSERT_AT, -1, 1, 1, 1'b0, 1'b1, '{0, ST_OK, 3}});
    plan.push_back('{FN_REMOVE_AT, 0, 3, 1, 1'b0, 1'b1, '{0, ST_BADPOS, 3}});
    plan.push_back('{FN_REMOVE_AT, 0, 1, 1, 1'b0, 1'b1, '{-1, ST_OK, 2}});
    plan.push_back('{FN_POP_BACK, 0, 0, 1, 1'b0, 1'b1, '{ValMin, ST_OK, 1}});
    plan.push_back('{FN_POP_FRONT, 0, 0, 1, 1'b0, 1'b1, '{ValMax, ST_OK, 0}});
    // insert at the count of an empty list is legal
    plan.push_back('{FN_INSERT_AT, 0, 0, 1, 1'b0, 1'b1, '{0, ST_OK, 1}});
    plan.push_back('{FN_PUSH_BACK, 0, 0, ListDepth - 1, 1'b1, 1'b0, none});
    // full list
    plan.push_back('{FN_PUSH_FRONT, 1, 0, 1, 1'b0, 1'b1, '{0, ST_FULL, ListDepth}});
    plan.push_back('{FN_INSERT_AT, 1, 17, 1, 1'b0, 1'b1, '{0, ST_BADPOS, ListDepth}});
    plan.push_back('{FN_INSERT_AT, 1, 16, 1, 1'b0, 1'b1, '{0, ST_FULL, ListDepth}});
    plan.push_back('{FN_PUSH_BACK, 1, 0, 1, 1'b0, 1'b1, '{0, ST_FULL, ListDepth}});
    plan.push_back('{FN_UNUSED_HI, 1, 0, 1, 1'b0, 1'b1, '{0, ST_OK, ListDepth}});
    plan.push_back('{FN_REMOVE_AT, 0, 16, 1, 1'b0, 1'b1, '{0, ST_BADPOS, ListDepth}});
    plan.push_back('{FN_REMOVE_AT, 0, 15, 1, 1'b0, 1'b0, none});
    plan.push_back('{FN_REMOVE_AT, 0, 0, 1, 1'b0, 1'b0, none});
    plan.push_back('{FN_INSERT_AT, 0, 7, 1, 1'b1, 1'b0, none});
    plan.push_back('{FN_INSERT_AT, 0, 15, 1, 1'b1, 1'b0, none});
    plan.push_back('{FN_POP_FRONT, 0, 0, 8, 1'b0, 1'b0, none});
    plan.push_back('{FN_POP_BACK, 0, 0, 8, 1'b0, 1'b0, none});
    plan.push_back('{FN_POP_BACK, 0, 0, 1, 1'b0, 1'b1, '{0, ST_EMPTY, 0}});

    // synchronous reset with inputs quiet, released at a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[k]) begin
      row = plan[k];
      repeat (row.reps) begin
        v = row.rnd_value ? DataW'($urandom) : row.value;
        send_cmd(row.op, v, row.pos, row.typed, row.want);
      end
    end

    // random part: drift between growing and draining so the count sweeps
    // the whole range, with full and empty errors along the way
    grow = 1'b1;
    for (int i = 0; i < RandItems; i++) begin
      // hold off halfway until every owed beat is back
      if (i == RandItems / 2) begin
        start <= 1'b0;
        @(negedge clk);
        while (due_results.size() != 0) @(negedge clk);
      end

      n = model_list.size();
      if (n == ListDepth && $urandom_range(0, 2) == 0) grow = 1'b0;
      else if (n == 0 && $urandom_range(0, 2) == 0) grow = 1'b1;
      else if ($urandom_range(0, 39) == 0) grow = !grow;

      roll = $urandom_range(0, 99);
      adds = 1'b0;
      if (roll < 3) begin
        op = FuncW'($urandom_range(FN_UNUSED_HI, FN_UNUSED_LO));
      end else if ((roll < 73) == grow) begin
        op = FuncW'($urandom_range(FN_INSERT_AT, FN_PUSH_FRONT));
        adds = 1'b1;
      end else begin
        op = FuncW'($urandom_range(FN_REMOVE_AT, FN_POP_FRONT));
      end

      // mostly legal positions, some anywhere in the field
      if ($urandom_range(0, 99) < 15) p = PosW'($urandom);
      else if (adds) p = PosW'($urandom_range(0, n));
      else p = (n == 0) ? '0 : PosW'($urandom_range(0, n - 1));

      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: v = ValMax;
          1: v = ValMin;
          2: v = '0;
          default: v = '1;
        endcase
      end else begin
        v = $urandom;
      end

      send_cmd(op, v, p, 1'b0, none);
    end

    // drain: wait for owed beats, then keep watching for strays
    start <= 1'b0;
    @(negedge clk);
    while (due_results.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    if (n_mismatch == 0) begin
      $display("PASS positional_insert_remove_list");
    end else begin
      $display("FAIL positional_insert_remove_list");
    end
    $finish;
  end

  // watchdog
  initial begin
    wait (n_cycles >= CycleLimit);
    $display("FAIL positional_insert_remove_list");
    $finish;
  end

endmodule
